// ----- rtl/ssfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ssfr_pkg
// Shared types, constants and the byte-wide CRC-16 update for the servo
// status-frame receiver.
// ----------------------------------------------------------------------------
package ssfr_pkg;

   // Default buffer limit for a whole frame, in bytes
   localparam int MAX_FRAME_BYTES_DEF = 64;

   // Header bytes
   localparam logic [7:0] HDR_SYNC   = 8'hFF;
   localparam logic [7:0] HDR_MARK   = 8'hFD;
   localparam logic [7:0] HDR_RSVD   = 8'h00;

   // Frame layout
   localparam int         HDR_BYTES      = 4;   // FF FF FD 00
   localparam int         FRAME_OVERHEAD = 7;   // total = length + 7
   localparam int         MIN_LENGTH     = 3;
   localparam int         REJECT_POS     = 9;   // tenth byte of the frame
   localparam int         ID_POS         = 4;
   localparam int         LEN_LO_POS     = 5;
   localparam int         LEN_HI_POS     = 6;
   localparam int         NUM_SERVOS     = 16;

   localparam logic [15:0] CRC_POLY = 16'h8005;

   typedef enum logic [1:0] {
      EV_NONE       = 2'd0,
      EV_ACCEPTED   = 2'd1,
      EV_CRC_ERROR  = 2'd2,
      EV_LEN_REJECT = 2'd3
   } event_type;

   // One byte into a non-reflected CRC-16, MSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc_i, input logic [7:0] b);
      logic [15:0] c;
      c = crc_i ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // CRC after the four header bytes
   localparam logic [15:0] HEADER_CRC =
      crc_feed(crc_feed(crc_feed(crc_feed(16'h0000, HDR_SYNC), HDR_SYNC), HDR_MARK), HDR_RSVD);

endpackage

// ----- rtl/servo_status_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// servo_status_frame_receiver
// Status-frame receiver for a half-duplex servo bus: header hunt, CRC check
// and a presence mask of the servos that have replied.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and returns exactly one result beat per
// byte. The receiver hunts the header FF FF FD 00, then latches the ID and the
// little-endian 16-bit length; the whole frame is length + 7 bytes. A CRC-16
// (poly 0x8005, MSB first, init 0) covers every byte except the last two, which
// carry the received CRC low byte first. On the last byte the result reports
// accepted (1), CRC mismatch (2) or, on the tenth byte of a frame whose length
// is under 3 or that would exceed MAX_FRAME_BYTES, length rejected (3). A good
// frame from ID 1..16 sets bit ID-1 of presence_mask, flagging a first sighting
// if that bit was clear. Payload bytes are counted and fed to the CRC only, not stored.
// Rate: one byte per clock while the output is not stalled; each result is
// registered as its byte is accepted. The longest path is the eight-step
// byte-wide CRC update feeding the frame-state registers. A single output
// register parts the sides: a new byte is taken whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module servo_status_frame_receiver #(
   parameter int MAX_FRAME_BYTES = ssfr_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_res,
   output logic [7:0]  rsp_frame_sender,
   output logic        rsp_sender_in_range,
   output logic        rsp_first_sighting,
   output logic [15:0] rsp_presence_mask
);

   // Position counter only needs to reach MAX_FRAME_BYTES - 1
   localparam int POS_W = $clog2(MAX_FRAME_BYTES);
   localparam int TOT_W = 17;   // 16-bit length plus overhead

   // ---- frame state ----
   logic [POS_W-1:0] pos_ff,      pos_in;
   logic [15:0]      len_ff,      len_in;
   logic [7:0]       sender_ff,   sender_in;
   logic [15:0]      crc_ff,      crc_in;
   logic [7:0]       crc_lo_ff,   crc_lo_in;
   logic [15:0]      seen_ff,     seen_in;

   // ---- result register ----
   logic             rsp_valid_ff;
   ssfr_pkg::event_type ev_ff, ev_in;
   logic [7:0]       out_sender_ff, out_sender_in;
   logic             in_range_ff,   in_range_in;
   logic             first_ff,      first_in;

   logic             req_fire;
   logic [7:0]       b;
   logic [7:0]       hdr_expect;
   logic [15:0]      crc_next;
   logic [TOT_W-1:0] total;
   logic [TOT_W-1:0] pos_wide;
   logic             len_bad;
   logic [3:0]       id_m1;
   logic [15:0]      id_bit;
   logic [15:0]      rx_crc;

   // Hold the input only while a finished result is stuck downstream
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign b         = req_rx_byte;

   assign crc_next  = ssfr_pkg::crc_feed(crc_ff, b);
   assign total     = TOT_W'(len_ff) + TOT_W'(ssfr_pkg::FRAME_OVERHEAD);
   assign pos_wide  = TOT_W'(pos_ff);
   assign len_bad   = (len_ff < 16'(ssfr_pkg::MIN_LENGTH)) ||
                      (total > TOT_W'(MAX_FRAME_BYTES));
   // ID 16 wraps to bit 15; only used once the ID is known to be in range
   assign id_m1     = sender_ff[3:0] - 4'd1;
   assign id_bit    = 16'd1 << id_m1;
   assign rx_crc    = {b, crc_lo_ff};

   // Expected header byte at the current hunt position
   always_comb begin
      unique case (pos_ff[1:0])
         2'd0:    hdr_expect = ssfr_pkg::HDR_SYNC;
         2'd1:    hdr_expect = ssfr_pkg::HDR_SYNC;
         2'd2:    hdr_expect = ssfr_pkg::HDR_MARK;
         default: hdr_expect = ssfr_pkg::HDR_RSVD;
      endcase
   end

   // Per-byte frame decode
   always_comb begin
      pos_in        = pos_ff;
      len_in        = len_ff;
      sender_in     = sender_ff;
      crc_in        = crc_ff;
      crc_lo_in     = crc_lo_ff;
      seen_in       = seen_ff;
      ev_in         = ssfr_pkg::EV_NONE;
      out_sender_in = 8'd0;
      in_range_in   = 1'b0;
      first_in      = 1'b0;

      if (pos_ff < POS_W'(ssfr_pkg::HDR_BYTES)) begin
         // header hunt; mismatch resyncs as though the window slid by one
         if (b == hdr_expect) begin
            pos_in = pos_ff + POS_W'(1);
            if (pos_ff == POS_W'(ssfr_pkg::HDR_BYTES - 1)) begin
               crc_in = ssfr_pkg::HEADER_CRC;
            end
         end else if (pos_ff == POS_W'(2) && b == ssfr_pkg::HDR_SYNC) begin
            pos_in = POS_W'(2);
         end else if (pos_ff == POS_W'(3) && b == ssfr_pkg::HDR_SYNC) begin
            pos_in = POS_W'(1);
         end else begin
            pos_in = '0;
         end
      end else if (pos_ff <= POS_W'(ssfr_pkg::LEN_HI_POS)) begin
         // ID and length bytes
         if (pos_ff == POS_W'(ssfr_pkg::ID_POS)) begin
            sender_in = b;
         end else if (pos_ff == POS_W'(ssfr_pkg::LEN_LO_POS)) begin
            len_in = {len_ff[15:8], b};
         end else begin
            len_in = {b, len_ff[7:0]};
         end
         crc_in = crc_next;
         pos_in = pos_ff + POS_W'(1);
      end else if (len_bad) begin
         // bad length: swallow up to the tenth byte, then report
         if (pos_ff >= POS_W'(ssfr_pkg::REJECT_POS)) begin
            ev_in         = ssfr_pkg::EV_LEN_REJECT;
            out_sender_in = sender_ff;
            pos_in        = '0;
            len_in        = '0;
            sender_in     = '0;
            crc_in        = '0;
            crc_lo_in     = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end else if (pos_wide < total - TOT_W'(2)) begin
         crc_in = crc_next;
         pos_in = pos_ff + POS_W'(1);
      end else if (pos_wide == total - TOT_W'(2)) begin
         crc_lo_in = b;
         pos_in    = pos_ff + POS_W'(1);
      end else begin
         // last byte: CRC high, frame ends
         out_sender_in = sender_ff;
         if (rx_crc == crc_ff) begin
            ev_in = ssfr_pkg::EV_ACCEPTED;
            if (sender_ff >= 8'd1 && sender_ff <= 8'(ssfr_pkg::NUM_SERVOS)) begin
               in_range_in = 1'b1;
               if ((seen_ff & id_bit) == 16'd0) begin
                  first_in = 1'b1;
                  seen_in  = seen_ff | id_bit;
               end
            end
         end else begin
            ev_in = ssfr_pkg::EV_CRC_ERROR;
         end
         pos_in    = '0;
         len_in    = '0;
         sender_in = '0;
         crc_in    = '0;
         crc_lo_in = '0;
      end
   end

   // Frame state, advanced once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         len_ff    <= '0;
         sender_ff <= '0;
         crc_ff    <= '0;
         crc_lo_ff <= '0;
         seen_ff   <= '0;
      end else if (req_fire) begin
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         sender_ff <= sender_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
         seen_ff   <= seen_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_fire || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ev_ff         <= ev_in;
         out_sender_ff <= out_sender_in;
         in_range_ff   <= in_range_in;
         first_ff      <= first_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = ev_ff;
   assign rsp_frame_sender    = out_sender_ff;
   assign rsp_sender_in_range = in_range_ff;
   assign rsp_first_sighting  = first_ff;
   // seen_ff only moves on an accepted beat, so it matches the held result
   assign rsp_presence_mask   = seen_ff;

   // ---- assertions ----

   // Presence bits are never cleared outside reset
   a_mask_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((seen_ff & $past(seen_ff)) == $past(seen_ff)))
      else $error("presence mask lost a bit");

   // While hunting the header the CRC accumulator stays cleared
   a_hunt_crc_clear: assert property (@(posedge clock) disable iff (reset)
      (pos_ff < POS_W'(ssfr_pkg::HDR_BYTES)) |-> (crc_ff == 16'd0))
      else $error("CRC not clear during header hunt");

   // A first sighting is only ever part of an accepted in-range frame
   a_first_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_first_sighting) |->
         (rsp_sender_in_range && ev_ff == ssfr_pkg::EV_ACCEPTED))
      else $error("first sighting without an accepted in-range frame");

   // A new presence bit always comes with a first-sighting result
   a_mask_grows_flagged: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && seen_ff != $past(seen_ff)) |-> (rsp_valid && rsp_first_sighting))
      else $error("presence mask changed without a first sighting");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the servo status-frame receiver.
// ----------------------------------------------------------------------------
// Bytes go in one beat at a time with random gaps. Every accepted byte is run
// through a bench-side model of the receiver: header hunt, length latch, CRC-16
// and the presence mask. The model queues one expected status beat per byte.
// A checker pops that queue on every accepted result beat and compares it field
// by field. Directed tests cover the header resync rules, the presence flags,
// CRC errors and the length limits. A held-off receiver fills the block's
// output register. Random frame traffic then runs with some noise mixed in.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_LIMIT    = ssfr_pkg::MAX_FRAME_BYTES_DEF;
   localparam int RANDOM_BYTES   = 140;
   localparam int REPORT_LIMIT   = 10;
   localparam int WATCHDOG_LIMIT = 500;  // above the longest correct quiet spell
   localparam int DRAIN_CYCLES   = 8;
   localparam int LONG_HOLD      = 48;

   typedef struct packed {
      ssfr_pkg::event_type ev;
      logic [7:0]  sender;
      logic        in_range;
      logic        first;
      logic [15:0] mask;
   } status_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_event_res;
   logic [7:0]  rsp_frame_sender;
   logic        rsp_sender_in_range;
   logic        rsp_first_sighting;
   logic [15:0] rsp_presence_mask;

   // bench-side receiver state
   int          hunt_pos     = 0;
   logic [15:0] frame_length = '0;
   logic [7:0]  frame_id     = '0;
   logic [15:0] frame_crc    = '0;
   logic [7:0]  crc_low      = '0;
   logic [15:0] seen_servos  = '0;

   status_beat_type expected_status_q[$];

   int mismatch_count = 0;
   int sent_bytes     = 0;
   int quiet_cycles   = 0;
   int hold_request   = 0;
   bit gaps_enable    = 1'b0;
   bit stall_enable   = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   servo_status_frame_receiver #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_res      (rsp_event_res),
      .rsp_frame_sender   (rsp_frame_sender),
      .rsp_sender_in_range(rsp_sender_in_range),
      .rsp_first_sighting (rsp_first_sighting),
      .rsp_presence_mask  (rsp_presence_mask)
   );

   // ---------------------------------------------------------------------
   // Model
   // ---------------------------------------------------------------------

   // CRC-16/0x8005, MSB first, one bit at a time
   function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = acc[15] ^ d[i];
         acc = {acc[14:0], 1'b0} ^ (fb ? ssfr_pkg::CRC_POLY : 16'h0000);
      end
      return acc;
   endfunction

   // back to hunting; the presence mask survives
   task automatic clear_frame();
      hunt_pos     = 0;
      frame_length = '0;
      frame_id     = '0;
      frame_crc    = '0;
      crc_low      = '0;
   endtask

   // one accepted byte -> one expected status beat
   task automatic predict_status(input logic [7:0] b);
      status_beat_type exp_beat;
      int              frame_total;
      exp_beat          = '0;
      exp_beat.ev       = ssfr_pkg::EV_NONE;
      if (hunt_pos < ssfr_pkg::HDR_BYTES) begin
         // a mismatch resyncs as if the buffered header bytes slid left by one
         case (hunt_pos)
            0: hunt_pos = (b == ssfr_pkg::HDR_SYNC) ? 1 : 0;
            1: hunt_pos = (b == ssfr_pkg::HDR_SYNC) ? 2 : 0;
            2: hunt_pos = (b == ssfr_pkg::HDR_MARK) ? 3 :
                          (b == ssfr_pkg::HDR_SYNC) ? 2 : 0;
            default: hunt_pos = (b == ssfr_pkg::HDR_RSVD) ? 4 :
                                (b == ssfr_pkg::HDR_SYNC) ? 1 : 0;
         endcase
         if (hunt_pos == ssfr_pkg::HDR_BYTES) begin
            frame_crc = crc16_update(crc16_update(crc16_update(crc16_update(
               16'h0000, ssfr_pkg::HDR_SYNC), ssfr_pkg::HDR_SYNC),
               ssfr_pkg::HDR_MARK), ssfr_pkg::HDR_RSVD);
         end
      end else if (hunt_pos <= ssfr_pkg::LEN_HI_POS) begin
         if (hunt_pos == ssfr_pkg::ID_POS) begin
            frame_id = b;
         end else if (hunt_pos == ssfr_pkg::LEN_LO_POS) begin
            frame_length[7:0] = b;
         end else begin
            frame_length[15:8] = b;
         end
         frame_crc = crc16_update(frame_crc, b);
         hunt_pos++;
      end else begin
         frame_total = int'(frame_length) + ssfr_pkg::FRAME_OVERHEAD;
         if (frame_length < ssfr_pkg::MIN_LENGTH || frame_total > FRAME_LIMIT) begin
            // rejected only once the tenth byte is in
            if (hunt_pos >= ssfr_pkg::REJECT_POS) begin
               exp_beat.ev     = ssfr_pkg::EV_LEN_REJECT;
               exp_beat.sender = frame_id;
               clear_frame();
            end else begin
               hunt_pos++;
            end
         end else if (hunt_pos < frame_total - 2) begin
            frame_crc = crc16_update(frame_crc, b);
            hunt_pos++;
         end else if (hunt_pos == frame_total - 2) begin
            crc_low = b;
            hunt_pos++;
         end else begin
            exp_beat.sender = frame_id;
            if ({b, crc_low} == frame_crc) begin
               exp_beat.ev = ssfr_pkg::EV_ACCEPTED;
               if (frame_id >= 1 && frame_id <= ssfr_pkg::NUM_SERVOS) begin
                  exp_beat.in_range = 1'b1;
                  if (!seen_servos[4'(frame_id - 8'd1)]) begin
                     exp_beat.first                   = 1'b1;
                     seen_servos[4'(frame_id - 8'd1)] = 1'b1;
                  end
               end
            end else begin
               exp_beat.ev = ssfr_pkg::EV_CRC_ERROR;
            end
            clear_frame();
         end
      end
      exp_beat.mask = seen_servos;
      expected_status_q.push_back(exp_beat);
   endtask

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------

   // One byte beat: optional idle gap, then hold the byte until taken.
   // Inputs move on the falling edge, the handshake is read on the rising one.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = gaps_enable ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      predict_status(b);
      sent_bytes++;
   endtask

   // Whole frame with a correct CRC, xored with crc_flip. An illegal length
   // gets just the three bytes that take it up to the reject point.
   task automatic send_frame(input logic [7:0] id, input logic [15:0] len,
                             input logic [15:0] crc_flip);
      logic [7:0]  frame_q[$];
      logic [15:0] crc;
      bit          too_long;
      too_long = (len < ssfr_pkg::MIN_LENGTH) ||
                 (int'(len) + ssfr_pkg::FRAME_OVERHEAD > FRAME_LIMIT);
      frame_q  = '{ssfr_pkg::HDR_SYNC, ssfr_pkg::HDR_SYNC, ssfr_pkg::HDR_MARK,
                   ssfr_pkg::HDR_RSVD, id, len[7:0], len[15:8]};
      if (too_long) begin
         repeat (ssfr_pkg::REJECT_POS + 1 - frame_q.size()) frame_q.push_back(8'($urandom));
      end else begin
         repeat (int'(len) - 2) frame_q.push_back(8'($urandom));
         crc = 16'h0000;
         foreach (frame_q[i]) crc = crc16_update(crc, frame_q[i]);
         crc ^= crc_flip;
         frame_q.push_back(crc[7:0]);
         frame_q.push_back(crc[15:8]);
      end
      foreach (frame_q[i]) send_byte(frame_q[i]);
   endtask

   // line noise, biased towards header bytes so the hunt gets exercised
   task automatic send_noise(input int count);
      logic [7:0] b;
      repeat (count) begin
         case ($urandom_range(0, 3))
            0: b = ssfr_pkg::HDR_SYNC;
            1: b = ssfr_pkg::HDR_MARK;
            2: b = ssfr_pkg::HDR_RSVD;
            default: b = 8'($urandom);
         endcase
         send_byte(b);
      end
   endtask

   // Receiver stall: random hold per beat, or a long hold when one is asked
   // for. The hold is counted here so the sender keeps offering meanwhile.
   initial begin : rsp_stall_gen
      int hold;
      forever begin
         if (hold_request > 0) begin
            hold         = hold_request;
            hold_request = 0;
         end else begin
            hold = stall_enable ? $urandom_range(0, 15) : 0;
         end
         if (hold > 0) begin
            @(negedge clock) rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock) rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t ns: %s", $time, msg);
      end
   endtask

   always @(posedge clock) begin : status_check
      status_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status_q.size() == 0) begin
            flag_error($sformatf("status beat with nothing pending: event %0d sender %02h",
                                 rsp_event_res, rsp_frame_sender));
         end else begin
            want = expected_status_q.pop_front();
            if (rsp_event_res !== want.ev) begin
               flag_error($sformatf("event: expected %s, got %0d",
                                    want.ev.name(), rsp_event_res));
            end
            if (rsp_frame_sender !== want.sender) begin
               flag_error($sformatf("frame_sender: expected %02h, got %02h",
                                    want.sender, rsp_frame_sender));
            end
            if (rsp_sender_in_range !== want.in_range) begin
               flag_error($sformatf("sender_in_range: expected %0b, got %0b",
                                    want.in_range, rsp_sender_in_range));
            end
            if (rsp_first_sighting !== want.first) begin
               flag_error($sformatf("first_sighting: expected %0b, got %0b",
                                    want.first, rsp_first_sighting));
            end
            if (rsp_presence_mask !== want.mask) begin
               flag_error($sformatf("presence_mask: expected %04h, got %04h",
                                    want.mask, rsp_presence_mask));
            end
         end
      end
   end

   // watchdog: too long without a beat on either side means a hang
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // every mismatch branch of the hunt, ending in sync on a real frame
   task automatic test_header_resync();
      logic [7:0] prefix_q[$];
      prefix_q = '{8'h00,                                   // wrong first byte
                   ssfr_pkg::HDR_SYNC, 8'h12,               // wrong second byte
                   ssfr_pkg::HDR_SYNC, ssfr_pkg::HDR_SYNC, 8'h00, // neither FD nor FF
                   ssfr_pkg::HDR_SYNC, ssfr_pkg::HDR_SYNC,
                   ssfr_pkg::HDR_MARK, 8'h01,               // neither 00 nor FF
                   ssfr_pkg::HDR_SYNC, ssfr_pkg::HDR_SYNC,
                   ssfr_pkg::HDR_SYNC,                      // FF FF FF holds at FF FF
                   ssfr_pkg::HDR_MARK, ssfr_pkg::HDR_SYNC}; // FF for 00 drops to one FF
      gaps_enable  = 1'b0;
      stall_enable = 1'b0;
      foreach (prefix_q[i]) send_byte(prefix_q[i]);
      send_frame(8'd3, 16'd3, 16'h0000);
   endtask

   // presence flags: edges of the ID range, repeat sighting, out-of-range IDs
   task automatic test_presence_flags();
      gaps_enable  = 1'b1;
      stall_enable = 1'b1;
      send_frame(8'd1,   16'd3, 16'h0000);
      send_frame(8'd16,  16'd4, 16'h0000);
      send_frame(8'd16,  16'd3, 16'h0000);   // already seen
      send_frame(8'd0,   16'd3, 16'h0000);
      send_frame(8'd17,  16'd3, 16'h0000);
      send_frame(8'hFF,  16'd3, 16'h0000);
   endtask

   task automatic test_crc_mismatch();
      send_frame(8'd5, 16'd3, 16'h0001);
      send_frame(8'd6, 16'd5, 16'h8000);
      send_frame(8'd6, 16'd3, 16'hFFFF);
   endtask

   // the longest legal frame, and rejects on both sides of the legal range
   task automatic test_length_limits();
      send_frame(8'd9,  16'(FRAME_LIMIT - ssfr_pkg::FRAME_OVERHEAD), 16'h0000);
      send_frame(8'd10, 16'(FRAME_LIMIT - ssfr_pkg::FRAME_OVERHEAD + 1), 16'h0000);
      send_frame(8'd11, 16'd2, 16'h0000);
      send_frame(8'd12, 16'd0, 16'h0000);
      send_frame(8'd13, 16'h0100, 16'h0000);
      send_frame(8'hAA, 16'hFFFF, 16'h0000);
   endtask

   // output held off while bytes pour in: the result register fills and
   // the input side must stall without losing a beat
   task automatic test_output_backpressure();
      gaps_enable  = 1'b0;
      stall_enable = 1'b0;
      hold_request = LONG_HOLD;
      send_frame(8'd7, 16'd3, 16'h0000);
      send_frame(8'd8, 16'd6, 16'h0000);
      send_frame(8'd2, 16'd3, 16'h0000);
   endtask

   // mostly good frames with random content; some CRC errors, bad lengths
   // and noise. Idling on each side switches on and off in stretches.
   task automatic test_random_traffic();
      int          stop_at;
      int          pick;
      logic [7:0]  id;
      logic [15:0] len;
      stop_at = sent_bytes + RANDOM_BYTES;
      while (sent_bytes < stop_at) begin
         if ($urandom_range(0, 5) == 0) gaps_enable  = !gaps_enable;
         if ($urandom_range(0, 5) == 0) stall_enable = !stall_enable;
         id   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17));
         len  = ($urandom_range(0, 7) == 0) ?
                16'($urandom_range(ssfr_pkg::MIN_LENGTH,
                                   FRAME_LIMIT - ssfr_pkg::FRAME_OVERHEAD)) :
                16'($urandom_range(ssfr_pkg::MIN_LENGTH, 8));
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            send_frame(id, len, 16'h0000);
         end else if (pick < 78) begin
            send_frame(id, len, 16'($urandom_range(1, 16'hFFFF)));
         end else if (pick < 88) begin
            len = ($urandom_range(0, 1) == 0) ?
                  16'($urandom_range(0, ssfr_pkg::MIN_LENGTH - 1)) :
                  16'($urandom_range(FRAME_LIMIT - ssfr_pkg::FRAME_OVERHEAD + 1, 16'hFFFF));
            send_frame(id, len, 16'h0000);
         end else begin
            send_noise($urandom_range(1, 6));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_header_resync();
      test_presence_flags();
      test_crc_mismatch();
      test_length_limits();
      test_output_backpressure();
      test_random_traffic();

      @(negedge clock) req_valid <= 1'b0;
      // the watchdog catches results that never come
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- servo_status_frame_receiver.f -----
rtl/ssfr_pkg.sv
rtl/servo_status_frame_receiver.sv
tb/tb.sv
